### hdl/lshf_pkg.sv
// Shared types, constants and filter coefficients for the luma subpel filter.
`timescale 1ns / 1ps

package lshf_pkg;

   // Geometry: four output columns, eight taps, eleven source pixels per row
   localparam int NUM_LANES  = 4;
   localparam int NUM_TAPS   = 8;
   localparam int NUM_PIX    = NUM_LANES + NUM_TAPS - 1;
   localparam int TAP_IDX_W  = $clog2(NUM_TAPS);

   // Data widths
   localparam int PIX_W      = 8;
   localparam int COEF_W     = 8;
   localparam int PROD_W     = 15;
   localparam int SAMPLE_W   = 16;
   localparam int PHASE_W    = 2;

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_LSB = 2;
   localparam logic CSR_IDX_PHASE = 1'b0;

   // Phase codes
   localparam logic [PHASE_W-1:0] PHASE_QUARTER = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_HALF    = 2'd2;
   localparam logic [PHASE_W-1:0] PHASE_RESET   = PHASE_QUARTER;

   typedef logic [PIX_W-1:0]           pix_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // Pipeline control from the top level to the lanes and the output stage
   typedef struct packed {
      logic load_products;
      logic load_result;
   } pipe_ctrl_type;

   // Filter taps, tap 0 applies to the leftmost pixel of the window
   localparam coef_type COEF_QUARTER [NUM_TAPS] = '{
      -8'sd1, 8'sd4, -8'sd10, 8'sd58, 8'sd17, -8'sd5, 8'sd1, 8'sd0
   };
   localparam coef_type COEF_HALF [NUM_TAPS] = '{
      -8'sd1, 8'sd4, -8'sd11, 8'sd40, 8'sd40, -8'sd11, 8'sd4, -8'sd1
   };
   localparam coef_type COEF_THREE_Q [NUM_TAPS] = '{
      8'sd0, 8'sd1, -8'sd5, 8'sd17, 8'sd58, -8'sd10, 8'sd4, -8'sd1
   };

   // Coefficient lookup; phase zero aliases the three-quarter filter
   function automatic coef_type tap_coef(input logic [PHASE_W-1:0] phase,
                                         input logic [TAP_IDX_W-1:0] tap);
      coef_type coef;
      unique case (phase)
         PHASE_QUARTER: coef = COEF_QUARTER[tap];
         PHASE_HALF:    coef = COEF_HALF[tap];
         default:       coef = COEF_THREE_Q[tap];
      endcase
      return coef;
   endfunction

endpackage

### hdl/lshf_req_if.sv
// Input channel: one row of source pixels plus the last-row mark.
`timescale 1ns / 1ps

interface lshf_req_if;
   logic              valid;
   logic              ready;
   lshf_pkg::pix_type pix_m3;
   lshf_pkg::pix_type pix_m2;
   lshf_pkg::pix_type pix_m1;
   lshf_pkg::pix_type pix_0;
   lshf_pkg::pix_type pix_1;
   lshf_pkg::pix_type pix_2;
   lshf_pkg::pix_type pix_3;
   lshf_pkg::pix_type pix_4;
   lshf_pkg::pix_type pix_5;
   lshf_pkg::pix_type pix_6;
   lshf_pkg::pix_type pix_7;
   logic              row_last;

   modport source (
      output valid, pix_m3, pix_m2, pix_m1, pix_0, pix_1, pix_2, pix_3,
             pix_4, pix_5, pix_6, pix_7, row_last,
      input  ready
   );
   modport sink (
      input  valid, pix_m3, pix_m2, pix_m1, pix_0, pix_1, pix_2, pix_3,
             pix_4, pix_5, pix_6, pix_7, row_last,
      output ready
   );
endinterface

// Result channel: four filtered samples plus the last-row mark.
interface lshf_rsp_if;
   logic                 valid;
   logic                 ready;
   lshf_pkg::sample_type out_0;
   lshf_pkg::sample_type out_1;
   lshf_pkg::sample_type out_2;
   lshf_pkg::sample_type out_3;
   logic                 row_last_out;

   modport source (
      output valid, out_0, out_1, out_2, out_3, row_last_out,
      input  ready
   );
   modport sink (
      input  valid, out_0, out_1, out_2, out_3, row_last_out,
      output ready
   );
endinterface

### hdl/luma_subpel_horizontal_filter.sv
// Top level of the luma subpel horizontal filter: register port, lanes, pipeline control.
`timescale 1ns / 1ps

// Usage:
//   req (sink): one row of eleven 8-bit pixels, offsets -3 to +7, plus row_last.
//   rsp (source): four signed 16-bit samples for columns 0..3, plus row_last_out.
//   Both channels transfer when valid and ready are high at a rising clock edge.
//   csr_*: APB-style port; register 0 at byte 0 is phase (1 quarter, 2 half,
//   3 three-quarter; 0 behaves as 3). Write only while the block is idle.
// Path: a row taken on req is registered as tap products, then as sums in the rsp register.
// Throughput: one row per cycle while rsp is ready. Four lanes each multiply eight taps in the
//   first stage and sum them into the output register in the second.
// Reset (synchronous, active high): pipeline emptied, phase set to quarter.
// Stall: a result held on rsp keeps its data; the stage behind it still takes
//   one more row, and req.ready drops only when both stages are full and rsp
//   is not ready.

module luma_subpel_horizontal_filter (
   input  logic                                clock,
   input  logic                                reset,
   lshf_req_if.sink                            req,
   lshf_rsp_if.source                          rsp,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lshf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [lshf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lshf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic [lshf_pkg::PHASE_W-1:0] phase_ff;
   logic [lshf_pkg::PHASE_W-1:0] phase_in;
   logic                         csr_write;
   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   logic                         row_last_ff;
   logic                         take_in;
   logic                         slot_free;
   lshf_pkg::pipe_ctrl_type      ctrl;
   lshf_pkg::pix_type            pix_row  [lshf_pkg::NUM_PIX];
   lshf_pkg::pix_type            lane_pix [lshf_pkg::NUM_LANES][lshf_pkg::NUM_TAPS];
   lshf_pkg::sample_type         lane_sum [lshf_pkg::NUM_LANES];

   // Register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = lshf_pkg::CSR_DATA_W'(phase_ff);

   always_comb begin
      phase_in = phase_ff;
      if (csr_write && csr_paddr[lshf_pkg::CSR_IDX_LSB] == lshf_pkg::CSR_IDX_PHASE) begin
         phase_in = csr_pwdata[lshf_pkg::PHASE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lshf_pkg::PHASE_RESET;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // Pipeline control: product stage moves on when the result slot frees up
   assign req.ready          = !s1_valid_ff || slot_free;
   assign take_in            = req.valid && req.ready;
   assign ctrl.load_products = take_in;
   assign ctrl.load_result   = s1_valid_ff && slot_free;

   always_comb begin
      if (take_in) begin
         s1_valid_in = 1'b1;
      end else if (ctrl.load_result) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         row_last_ff <= req.row_last;
      end
   end

   // Source window, then each lane's eight-pixel slice
   assign pix_row[0]  = req.pix_m3;
   assign pix_row[1]  = req.pix_m2;
   assign pix_row[2]  = req.pix_m1;
   assign pix_row[3]  = req.pix_0;
   assign pix_row[4]  = req.pix_1;
   assign pix_row[5]  = req.pix_2;
   assign pix_row[6]  = req.pix_3;
   assign pix_row[7]  = req.pix_4;
   assign pix_row[8]  = req.pix_5;
   assign pix_row[9]  = req.pix_6;
   assign pix_row[10] = req.pix_7;

   always_comb begin
      for (int c = 0; c < lshf_pkg::NUM_LANES; c++) begin
         for (int t = 0; t < lshf_pkg::NUM_TAPS; t++) begin
            lane_pix[c][t] = pix_row[c + t];
         end
      end
   end

   // Filter lanes, one per output column
   for (genvar c = 0; c < lshf_pkg::NUM_LANES; c++) begin : g_lane
      lshf_lane u_lane (
         .clock (clock),
         .ctrl  (ctrl),
         .phase (phase_ff),
         .pix   (lane_pix[c]),
         .sum   (lane_sum[c])
      );
   end

   // Result register
   lshf_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .lane_sum  (lane_sum),
      .row_last  (row_last_ff),
      .slot_free (slot_free),
      .rsp       (rsp)
   );

`ifndef ASSERT_OFF
   // A row is taken into a full product stage only when that stage drains
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      take_in && s1_valid_ff |-> ctrl.load_result)
      else $error("product stage overwritten");

   // Loading the result register always presents a result next cycle
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_result |=> rsp.valid)
      else $error("loaded result not presented");

   // A phase write lands in the phase register
   a_phase_write: assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_paddr[lshf_pkg::CSR_IDX_LSB] == lshf_pkg::CSR_IDX_PHASE
      |=> phase_ff == $past(csr_pwdata[lshf_pkg::PHASE_W-1:0]))
      else $error("phase write lost");
`endif

endmodule

### hdl/lshf_lane.sv
// One filter lane: eight tap products registered, then summed into one sample.
`timescale 1ns / 1ps

module lshf_lane (
   input  logic                                  clock,
   input  lshf_pkg::pipe_ctrl_type               ctrl,
   input  logic [lshf_pkg::PHASE_W-1:0]          phase,
   input  lshf_pkg::pix_type                     pix [lshf_pkg::NUM_TAPS],
   output lshf_pkg::sample_type                  sum
);

   lshf_pkg::prod_type product_ff [lshf_pkg::NUM_TAPS];
   lshf_pkg::prod_type product_in [lshf_pkg::NUM_TAPS];

   // Tap products: small constant coefficients times unsigned pixels
   always_comb begin
      lshf_pkg::prod_type coef_ext;
      lshf_pkg::prod_type pix_ext;
      for (int t = 0; t < lshf_pkg::NUM_TAPS; t++) begin
         coef_ext      = lshf_pkg::PROD_W'(lshf_pkg::tap_coef(phase,
                                           lshf_pkg::TAP_IDX_W'(t)));
         pix_ext       = lshf_pkg::PROD_W'({1'b0, pix[t]});
         product_in[t] = coef_ext * pix_ext;
      end
   end

   // Product register, loaded on an input transfer
   always_ff @(posedge clock) begin
      if (ctrl.load_products) begin
         product_ff <= product_in;
      end
   end

   // Sum of the registered products; the exact total fits the sample width
   always_comb begin
      sum = '0;
      for (int t = 0; t < lshf_pkg::NUM_TAPS; t++) begin
         sum = sum + lshf_pkg::SAMPLE_W'(product_ff[t]);
      end
   end

endmodule

### hdl/lshf_merge.sv
// Output stage: gathers the lane sums and the row mark into one result register.
`timescale 1ns / 1ps

module lshf_merge (
   input  logic                    clock,
   input  logic                    reset,
   input  lshf_pkg::pipe_ctrl_type ctrl,
   input  lshf_pkg::sample_type    lane_sum [lshf_pkg::NUM_LANES],
   input  logic                    row_last,
   output logic                    slot_free,
   lshf_rsp_if.source              rsp
);

   logic                 valid_ff;
   logic                 valid_in;
   lshf_pkg::sample_type sample_ff [lshf_pkg::NUM_LANES];
   logic                 row_last_ff;

   // Result slot can take new data when empty or when its transfer completes
   assign slot_free = !valid_ff || rsp.ready;

   always_comb begin
      if (ctrl.load_result) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (ctrl.load_result) begin
         sample_ff   <= lane_sum;
         row_last_ff <= row_last;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.out_0        = sample_ff[0];
   assign rsp.out_1        = sample_ff[1];
   assign rsp.out_2        = sample_ff[2];
   assign rsp.out_3        = sample_ff[3];
   assign rsp.row_last_out = row_last_ff;

endmodule
